@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define WRCE_ASSERT(label, ck, rn, prop) \
	label: assert property (@(posedge ck) disable iff (!rn) (prop)) \
	else $error("wrce assertion failed");
// consequent must hold whenever the antecedent holds
`define WRCE_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("wrce implication failed");
`else
`define WRCE_ASSERT(label, ck, rn, prop)
`define WRCE_ASSERT_IMP(label, ck, rn, ante, cons)
`endif
`endif

@@ sv/wrce_pkg.sv @@
package wrce_pkg;

	// only report bytes 0..8 are ever compared, so only those are kept
	localparam int KEEP_BYTES = 9;
	localparam int KEEP_BITS  = KEEP_BYTES * 8;
	localparam int BIT_IDX_W  = $clog2(KEEP_BITS);
	localparam int BYTE_IDX_W = $clog2(KEEP_BYTES);
	localparam int COUNT_W    = 6;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// report queue and event queue depths
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int OUT_DEPTH  = 2;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

	typedef logic [2:0] model_t;
	typedef logic [KEEP_BYTES-1:0][7:0] report_t;

	// wheel model codes
	localparam model_t WM_M0 = 3'd0;
	localparam model_t WM_M1 = 3'd1;
	localparam model_t WM_M2 = 3'd2;
	localparam model_t WM_M3 = 3'd3;
	localparam model_t WM_M4 = 3'd4;
	localparam model_t WM_M5 = 3'd5;

	// per-model layout tables, unused codes accept no length
	localparam logic [COUNT_W-1:0] LEN_TAB [8] = '{
		6'd12, 6'd11, 6'd11, 6'd8, 6'd8, 6'd27, 6'd0, 6'd0};
	localparam logic [5:0] BOFF_TAB [8] = '{
		6'd4, 6'd4, 6'd4, 6'd4, 6'd14, 6'd0, 6'd0, 6'd0};
	localparam logic [4:0] BCNT_TAB [8] = '{
		5'd25, 5'd22, 5'd19, 5'd21, 5'd14, 5'd13, 5'd0, 5'd0};

	typedef enum logic [1:0] {
		EV_HAT    = 2'd0,
		EV_BUTTON = 2'd1,
		EV_AXIS   = 2'd2,
		EV_DONE   = 2'd3
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [4:0]  index;
		logic [15:0] value;
		logic        last;
	} event_t;

	typedef enum logic [2:0] {
		AX_NONE,
		AX_BYTE,
		AX_W16,
		AX_W14_SHIFT,
		AX_W14_HI
	} ax_mode_t;

	// one axis check: how to build the key, which axis, low and high byte
	typedef struct packed {
		ax_mode_t   mode;
		logic [1:0] axis;
		logic [3:0] pos;
		logic [3:0] hi;
	} ax_slot_t;

	// hat nibble to direction mask
	function automatic logic [3:0] hat_mask(input logic [3:0] n);
		logic [3:0] m;
		unique case (n)
			4'd0: m = 4'd1;
			4'd1: m = 4'd3;
			4'd2: m = 4'd2;
			4'd3: m = 4'd6;
			4'd4: m = 4'd4;
			4'd5: m = 4'd12;
			4'd6: m = 4'd8;
			4'd7: m = 4'd9;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

	// axis layout per model and check slot
	function automatic ax_slot_t axis_slot(input model_t m, input logic [1:0] k);
		ax_slot_t s;
		s = '{AX_NONE, 2'd0, 4'd0, 4'd0};
		unique case (m) inside
			WM_M0: begin
				unique case (k)
					2'd0: s = '{AX_W16, 2'd0, 4'd4, 4'd5};
					2'd1: s = '{AX_BYTE, 2'd2, 4'd6, 4'd0};
					2'd2: s = '{AX_BYTE, 2'd3, 4'd7, 4'd0};
					default: s = '{AX_BYTE, 2'd1, 4'd8, 4'd0};
				endcase
			end
			WM_M1, WM_M2: begin
				unique case (k)
					2'd0: s = '{AX_W14_SHIFT, 2'd0, 4'd3, 4'd4};
					2'd1: s = '{AX_BYTE, 2'd2, 4'd5, 4'd0};
					2'd2: s = '{AX_BYTE, 2'd3, 4'd6, 4'd0};
					default: s = '{AX_BYTE, 2'd1, 4'd7, 4'd0};
				endcase
			end
			WM_M3: begin
				unique case (k)
					2'd0: s = '{AX_W14_HI, 2'd0, 4'd4, 4'd5};
					2'd1: s = '{AX_BYTE, 2'd1, 4'd6, 4'd0};
					2'd2: s = '{AX_BYTE, 2'd2, 4'd7, 4'd0};
					default: s = '{AX_NONE, 2'd0, 4'd0, 4'd0};
				endcase
			end
			WM_M4: begin
				unique case (k)
					2'd0: s = '{AX_W14_HI, 2'd0, 4'd0, 4'd1};
					2'd1: s = '{AX_BYTE, 2'd1, 4'd5, 4'd0};
					2'd2: s = '{AX_BYTE, 2'd2, 4'd6, 4'd0};
					default: s = '{AX_NONE, 2'd0, 4'd0, 4'd0};
				endcase
			end
			WM_M5: begin
				unique case (k)
					2'd0: s = '{AX_BYTE, 2'd0, 4'd3, 4'd0};
					2'd1: s = '{AX_BYTE, 2'd1, 4'd4, 4'd0};
					2'd2: s = '{AX_BYTE, 2'd2, 4'd5, 4'd0};
					default: s = '{AX_BYTE, 2'd3, 4'd6, 4'd0};
				endcase
			end
			default: s = '{AX_NONE, 2'd0, 4'd0, 4'd0};
		endcase
		return s;
	endfunction

	// comparison key of an axis, 14-bit axes zero-extended
	function automatic logic [15:0] axis_key(input report_t r, input ax_slot_t s);
		logic [15:0] key;
		unique case (s.mode)
			AX_BYTE:      key = {8'd0, r[s.pos]};
			AX_W16:       key = {r[s.hi], r[s.pos]};
			AX_W14_SHIFT: key = {2'd0, r[s.hi], r[s.pos][7:2]};
			AX_W14_HI:    key = {2'd0, r[s.hi][5:0], r[s.pos]};
			default:      key = 16'd0;
		endcase
		return key;
	endfunction

	// reported axis value: offset to signed, byte axes replicated
	function automatic logic [15:0] axis_value(input logic [15:0] key, input ax_mode_t mode);
		logic [15:0] v;
		unique case (mode) inside
			AX_BYTE:                v = {key[7:0], key[7:0]} ^ 16'h8000;
			AX_W16:                 v = key ^ 16'h8000;
			AX_W14_SHIFT, AX_W14_HI: v = {key[13:0], 2'b00} ^ 16'h8000;
			default:                v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/wheel_report_change_events_top.sv @@
// Wheel report change-event generator. Report bytes are pushed one per transfer,
// byte zero first, with end_of_report on the last byte; a byte is taken whenever
// full is low. A report whose length matches the selected wheel model is
// snapshotted into a two-entry report queue; any other length is dropped
// without events. The back end walks one check per cycle over the snapshot
// against the stored previous report: the hat, each button of the model, four
// axis slots and the done event, then an idle state; a check with an event to
// emit stalls while the two-entry event queue is full. full stays high while
// both report snapshots are waiting. Events are popped from the event queue:
// kind, index, value and last_of_run (set on the done event, whose value is the
// changed flag). The wheel model register is written over the cfg channel,
// which is always ready, and must only change while no report is in flight.
module wheel_report_change_events_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	input  logic               end_of_report,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         event_kind,
	output logic [4:0]         event_index,
	output logic signed [15:0] event_value,
	output logic               last_of_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_wheel_model
);

	wrce_pkg::model_t   model_q;
	logic               accept;
	logic               q_push;
	wrce_pkg::report_t  q_data;
	logic               q_pop;
	logic               q_full;
	logic               q_valid;
	wrce_pkg::report_t  q_head;
	wrce_pkg::event_t   out_ev;

	// wheel model register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= wrce_pkg::WM_M0;
		end else if (cfg_valid && cfg_ready) begin
			model_q <= cfg_wheel_model;
		end
	end

	// input transfer
	assign full   = q_full;
	assign accept = push && !full;

	wrce_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_report (end_of_report),
		.model         (model_q),
		.q_push        (q_push),
		.q_data        (q_data)
	);

	wrce_rpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head)
	);

	wrce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.model   (model_q),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.out_ev  (out_ev)
	);

	// result fields
	assign event_kind  = out_ev.kind;
	assign event_index = out_ev.index;
	assign event_value = $signed(out_ev.value);
	assign last_of_run = out_ev.last;

endmodule

@@ sv/wrce_front.sv @@
module wrce_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               data_byte,
	input  logic                     end_of_report,
	input  wrce_pkg::model_t         model,
	output logic                     q_push,
	output wrce_pkg::report_t        q_data
);

	wrce_pkg::report_t               cur_q;
	wrce_pkg::report_t               cur_next;
	logic [wrce_pkg::COUNT_W-1:0]    cnt_q;
	logic [wrce_pkg::COUNT_W-1:0]    cnt_inc;

	// merge incoming byte, saturate the count
	always_comb begin
		cur_next = cur_q;
		if (cnt_q < wrce_pkg::COUNT_W'(wrce_pkg::KEEP_BYTES)) begin
			cur_next[cnt_q[wrce_pkg::BYTE_IDX_W-1:0]] = data_byte;
		end
		cnt_inc = (cnt_q == wrce_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	end

	// hand a report of the right length to the back end
	assign q_push = accept && end_of_report && (cnt_inc == wrce_pkg::LEN_TAB[model])
		&& (cnt_inc != '0);
	assign q_data = cur_next;

	// report byte capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= cur_next;
		end
	end

	// byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= end_of_report ? '0 : cnt_inc;
		end
	end

endmodule

@@ sv/wrce_rpt_queue.sv @@
`include "assert_macros.svh"

module wrce_rpt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wrce_pkg::report_t    push_data,
	input  logic                 pop,
	output logic                 full,
	output logic                 valid,
	output wrce_pkg::report_t    head
);

	wrce_pkg::report_t                 mem_q [wrce_pkg::QDEPTH];
	logic [wrce_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [wrce_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [wrce_pkg::QPTR_W:0]         cnt_q;

	assign full  = (cnt_q == (wrce_pkg::QPTR_W + 1)'(wrce_pkg::QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// snapshot storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`WRCE_ASSERT(a_q_cnt_range, clk, arst_n, cnt_q <= (wrce_pkg::QPTR_W + 1)'(wrce_pkg::QDEPTH))
	`WRCE_ASSERT_IMP(a_q_no_overflow, clk, arst_n, push, !full || pop)
	`WRCE_ASSERT_IMP(a_q_no_underflow, clk, arst_n, pop, valid)

endmodule

@@ sv/wrce_back.sv @@
`include "assert_macros.svh"

module wrce_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wrce_pkg::model_t     model,
	input  logic                 q_valid,
	input  wrce_pkg::report_t    q_head,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output wrce_pkg::event_t     out_ev
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HAT,
		ST_BTN,
		ST_AXIS,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [4:0]                        idx_q;
	logic                              changed_q;
	wrce_pkg::report_t                 prev_q;

	wrce_pkg::event_t                  ev;
	logic                              want;
	logic                              push_out;
	logic                              step;
	logic [3:0]                        cur_hat;
	logic [3:0]                        prev_hat;
	logic [wrce_pkg::KEEP_BITS-1:0]    cur_flat;
	logic [wrce_pkg::KEEP_BITS-1:0]    prev_flat;
	logic [wrce_pkg::BIT_IDX_W-1:0]    bit_pos;
	wrce_pkg::ax_slot_t                slot;
	logic [15:0]                       cur_key;
	logic [15:0]                       prev_key;

	wrce_pkg::event_t                  ev_q [wrce_pkg::OUT_DEPTH];
	logic [wrce_pkg::OUT_PTR_W-1:0]    out_wr_q;
	logic [wrce_pkg::OUT_PTR_W-1:0]    out_rd_q;
	logic [wrce_pkg::OUT_PTR_W:0]      out_cnt_q;
	logic                              out_full;
	logic                              out_pop;

	// hat nibble location depends on the model
	always_comb begin
		unique case (model)
			wrce_pkg::WM_M4: begin
				cur_hat  = q_head[3][7:4];
				prev_hat = prev_q[3][7:4];
			end
			wrce_pkg::WM_M5: begin
				cur_hat  = q_head[2][3:0];
				prev_hat = prev_q[2][3:0];
			end
			default: begin
				cur_hat  = q_head[0][3:0];
				prev_hat = prev_q[0][3:0];
			end
		endcase
	end

	// button bit and axis slot for the current check
	assign cur_flat  = q_head;
	assign prev_flat = prev_q;
	assign bit_pos   = wrce_pkg::BIT_IDX_W'(wrce_pkg::BOFF_TAB[model])
		+ wrce_pkg::BIT_IDX_W'(idx_q);
	assign slot      = wrce_pkg::axis_slot(model, idx_q[1:0]);
	assign cur_key   = wrce_pkg::axis_key(q_head, slot);
	assign prev_key  = wrce_pkg::axis_key(prev_q, slot);

	// event candidate of the current check
	always_comb begin
		ev   = '{wrce_pkg::EV_HAT, 5'd0, 16'd0, 1'b0};
		want = 1'b0;
		unique case (state_q)
			ST_HAT: begin
				want = (cur_hat != prev_hat);
				ev   = '{wrce_pkg::EV_HAT, 5'd0, {12'd0, wrce_pkg::hat_mask(cur_hat)}, 1'b0};
			end
			ST_BTN: begin
				want = (cur_flat[bit_pos] != prev_flat[bit_pos]);
				ev   = '{wrce_pkg::EV_BUTTON, idx_q, {15'd0, cur_flat[bit_pos]}, 1'b0};
			end
			ST_AXIS: begin
				want = (slot.mode != wrce_pkg::AX_NONE) && (cur_key != prev_key);
				ev   = '{wrce_pkg::EV_AXIS, {3'd0, slot.axis},
					wrce_pkg::axis_value(cur_key, slot.mode), 1'b0};
			end
			ST_DONE: begin
				want = 1'b1;
				ev   = '{wrce_pkg::EV_DONE, 5'd0, {15'd0, changed_q}, 1'b1};
			end
			default: begin
				want = 1'b0;
			end
		endcase
	end

	// advance unless an event has no room
	assign out_full = (out_cnt_q == (wrce_pkg::OUT_PTR_W + 1)'(wrce_pkg::OUT_DEPTH));
	assign step     = (state_q != ST_IDLE) && !(want && out_full);
	assign push_out = step && want;
	assign q_pop    = step && (state_q == ST_DONE);

	// check sequencer, previous report store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			changed_q <= 1'b0;
			prev_q    <= '0;
		end else begin
			if (push_out && (state_q != ST_DONE)) begin
				changed_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q   <= ST_HAT;
						changed_q <= 1'b0;
					end
				end
				ST_HAT: begin
					if (step) begin
						state_q <= ST_BTN;
						idx_q   <= '0;
					end
				end
				ST_BTN: begin
					if (step) begin
						if (idx_q == wrce_pkg::BCNT_TAB[model] - 1'b1) begin
							state_q <= ST_AXIS;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_AXIS: begin
					if (step) begin
						if (idx_q[1:0] == 2'd3) begin
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (step) begin
						state_q <= ST_IDLE;
						for (int k = 0; k < wrce_pkg::KEEP_BYTES; k++) begin
							if (wrce_pkg::COUNT_W'(k) < wrce_pkg::LEN_TAB[model]) begin
								prev_q[k] <= q_head[k];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// event queue toward the consumer
	assign empty   = (out_cnt_q == '0);
	assign out_pop = pop && !empty;
	assign out_ev  = ev_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (push_out) begin
			ev_q[out_wr_q] <= ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (push_out) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			if (push_out && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_pop && !push_out) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	`WRCE_ASSERT(a_out_cnt_range, clk, arst_n, out_cnt_q <= (wrce_pkg::OUT_PTR_W + 1)'(wrce_pkg::OUT_DEPTH))
	`WRCE_ASSERT_IMP(a_run_has_report, clk, arst_n, state_q != ST_IDLE, q_valid)
	`WRCE_ASSERT_IMP(a_btn_in_range, clk, arst_n, state_q == ST_BTN, idx_q < wrce_pkg::BCNT_TAB[model])

endmodule

@@ test/tb_wheel_report_change_events_top.sv @@
module tb_wheel_report_change_events_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 6;
	localparam int IDLE_PCT      = 11;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_BYTES  = 180;
	localparam int NUM_PHASES    = 8;
	// a code with no report layout, every report is dropped
	localparam wrce_pkg::model_t WM_UNUSED = 3'd7;

	// tracks the stored report and predicts the change events of each report
	class wheel_event_tracker;
		logic [31:0][7:0] prev_rep;
		logic [31:0][7:0] cur_rep;
		int unsigned fill;
		wrce_pkg::model_t model;
		bit changed;
		wrce_pkg::event_t pending [$];
		int errors;

		function new();
			prev_rep = '0;
			cur_rep  = '0;
			fill     = 0;
			model    = wrce_pkg::WM_M0;
			changed  = 1'b0;
			errors   = 0;
		endfunction

		function void set_model(wrce_pkg::model_t m);
			model = m;
		endfunction

		function void emit(wrce_pkg::ev_kind_t k, int unsigned idx, int unsigned val, bit last);
			wrce_pkg::event_t ev;
			ev.kind  = k;
			ev.index = idx[4:0];
			ev.value = val[15:0];
			ev.last  = last;
			pending.push_back(ev);
		endfunction

		// single byte axis, value spread over 16 bits
		function void byte_axis(int unsigned axis, int unsigned pos);
			if (cur_rep[pos] != prev_rep[pos]) begin
				changed = 1'b1;
				emit(wrce_pkg::EV_AXIS, axis, cur_rep[pos] * 257 + 32768, 1'b0);
			end
		endfunction

		// wheel axis built from two bytes
		function void wide_axis(int unsigned now_key, int unsigned was_key, int unsigned scale);
			if (now_key != was_key) begin
				changed = 1'b1;
				emit(wrce_pkg::EV_AXIS, 0, now_key * scale + 32768, 1'b0);
			end
		endfunction

		// one accepted report byte, events queued when a report of the right length closes
		function void note_byte(logic [7:0] d, logic e);
			int unsigned len, want_len, boff, bcnt, hat_now, hat_was, mask, i;
			logic [255:0] now_bits, was_bits;
			if (fill < 32)
				cur_rep[fill] = d;
			if (fill < 63)
				fill++;
			if (!e)
				return;
			len  = fill;
			fill = 0;
			case (model)
				wrce_pkg::WM_M0: begin want_len = 12; boff = 4; bcnt = 25; end
				wrce_pkg::WM_M1: begin want_len = 11; boff = 4; bcnt = 22; end
				wrce_pkg::WM_M2: begin want_len = 11; boff = 4; bcnt = 19; end
				wrce_pkg::WM_M3: begin want_len = 8; boff = 4; bcnt = 21; end
				wrce_pkg::WM_M4: begin want_len = 8; boff = 14; bcnt = 14; end
				wrce_pkg::WM_M5: begin want_len = 27; boff = 0; bcnt = 13; end
				default: begin want_len = 0; boff = 0; bcnt = 0; end
			endcase
			if (want_len == 0 || len != want_len)
				return;
			changed = 1'b0;

			// hat nibble location depends on the model
			if (model == wrce_pkg::WM_M4) begin
				hat_now = cur_rep[3][7:4];
				hat_was = prev_rep[3][7:4];
			end else if (model == wrce_pkg::WM_M5) begin
				hat_now = cur_rep[2][3:0];
				hat_was = prev_rep[2][3:0];
			end else begin
				hat_now = cur_rep[0][3:0];
				hat_was = prev_rep[0][3:0];
			end
			if (hat_now != hat_was) begin
				case (hat_now)
					0: mask = 1;
					1: mask = 3;
					2: mask = 2;
					3: mask = 6;
					4: mask = 4;
					5: mask = 12;
					6: mask = 8;
					7: mask = 9;
					default: mask = 0;
				endcase
				changed = 1'b1;
				emit(wrce_pkg::EV_HAT, 0, mask, 1'b0);
			end

			// buttons in ascending order
			now_bits = cur_rep;
			was_bits = prev_rep;
			for (i = 0; i < bcnt; i++) begin
				if (now_bits[boff + i] != was_bits[boff + i]) begin
					changed = 1'b1;
					emit(wrce_pkg::EV_BUTTON, i, now_bits[boff + i], 1'b0);
				end
			end

			// axes in the fixed order of each layout
			case (model) inside
				wrce_pkg::WM_M0: begin
					wide_axis({cur_rep[5], cur_rep[4]}, {prev_rep[5], prev_rep[4]}, 1);
					byte_axis(2, 6);
					byte_axis(3, 7);
					byte_axis(1, 8);
				end
				wrce_pkg::WM_M1, wrce_pkg::WM_M2: begin
					wide_axis({cur_rep[4], cur_rep[3][7:2]}, {prev_rep[4], prev_rep[3][7:2]}, 4);
					byte_axis(2, 5);
					byte_axis(3, 6);
					byte_axis(1, 7);
				end
				wrce_pkg::WM_M3: begin
					wide_axis({cur_rep[5][5:0], cur_rep[4]}, {prev_rep[5][5:0], prev_rep[4]}, 4);
					byte_axis(1, 6);
					byte_axis(2, 7);
				end
				wrce_pkg::WM_M4: begin
					wide_axis({cur_rep[1][5:0], cur_rep[0]}, {prev_rep[1][5:0], prev_rep[0]}, 4);
					byte_axis(1, 5);
					byte_axis(2, 6);
				end
				default: begin
					byte_axis(0, 3);
					byte_axis(1, 4);
					byte_axis(2, 5);
					byte_axis(3, 6);
				end
			endcase

			emit(wrce_pkg::EV_DONE, 0, changed, 1'b1);
			for (i = 0; i < len && i < 32; i++)
				prev_rep[i] = cur_rep[i];
		endfunction

		// compare one popped event with the oldest prediction
		function void check_event(logic [1:0] kind, logic [4:0] idx, logic [15:0] val, logic last);
			wrce_pkg::event_t want;
			if (pending.size() == 0) begin
				$error("unexpected event kind %0d index %0d value %0h", kind, idx, val);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (kind !== want.kind) begin
				$error("event_kind expected %0d actual %0d", want.kind, kind);
				errors++;
			end
			if (idx !== want.index) begin
				$error("event_index expected %0d actual %0d", want.index, idx);
				errors++;
			end
			if (val !== want.value) begin
				$error("event_value expected %0h actual %0h", want.value, val);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_run expected %0d actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] data_byte;
	logic end_of_report;
	logic empty;
	logic pop;
	logic [1:0] event_kind;
	logic [4:0] event_index;
	logic signed [15:0] event_value;
	logic last_of_run;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_wheel_model;

	wheel_event_tracker tracker = new();
	logic [31:0][7:0] shadow;
	bit calm;
	int stall_cycles;

	wheel_report_change_events_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_report  (end_of_report),
		.empty          (empty),
		.pop            (pop),
		.event_kind     (event_kind),
		.event_index    (event_index),
		.event_value    (event_value),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_wheel_model(cfg_wheel_model)
	);

	always #CLK_HALF clk = ~clk;

	// event side: check each transfer, then pick the next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				tracker.check_event(event_kind, event_index, event_value, last_of_run);
			pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// one byte transfer with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] d, input logic e);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		data_byte     <= d;
		end_of_report <= e;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tracker.note_byte(d, e);
	endtask

	// report of n bytes: flips < 0 gives fresh content, else the last report with bit flips
	task automatic send_report(input int unsigned n, input int flips);
		int unsigned i, lim, pos;
		logic [7:0] b;
		lim = (n < 12) ? n : 12;
		for (int k = 0; k < flips; k++) begin
			pos = $urandom_range(0, lim - 1);
			shadow[pos] = shadow[pos] ^ (8'd1 << $urandom_range(0, 7));
		end
		for (i = 0; i < n; i++) begin
			b = (flips < 0 || i >= 32) ? 8'($urandom) : shadow[i];
			if (i < 32)
				shadow[i] = b;
			send_byte(b, i == n - 1);
		end
	endtask

	// hold the sender until every predicted event is out, then let the block settle
	task automatic drain();
		push <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_model(input wrce_pkg::model_t m);
		cfg_valid       <= 1'b1;
		cfg_wheel_model <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tracker.set_model(m);
	endtask

	initial begin
		wrce_pkg::model_t phase_models [NUM_PHASES];
		int unsigned n, good_len, phase_bytes, pick;
		int flips;
		phase_models = '{wrce_pkg::WM_M5, wrce_pkg::WM_M1, wrce_pkg::WM_M2, wrce_pkg::WM_M3,
			wrce_pkg::WM_M4, WM_UNUSED, wrce_pkg::WM_M0, wrce_pkg::WM_M5};

		arst_n          = 1'b0;
		push            = 1'b0;
		data_byte       = 8'd0;
		end_of_report   = 1'b0;
		pop             = 1'b0;
		cfg_valid       = 1'b0;
		cfg_wheel_model = wrce_pkg::WM_M0;
		calm            = 1'b0;
		stall_cycles    = 0;
		shadow          = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every bit set, every bit cleared, then a short report that is dropped
		write_model(wrce_pkg::WM_M0);
		shadow = '1;
		send_report(12, 0);
		shadow = '0;
		send_report(12, 0);
		send_report(3, -1);

		// random phases, one model each, mostly well-formed reports with few changes
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_model(phase_models[p]);
			calm = (p == 3);
			case (phase_models[p]) inside
				wrce_pkg::WM_M0: good_len = 12;
				wrce_pkg::WM_M1, wrce_pkg::WM_M2: good_len = 11;
				wrce_pkg::WM_M3, wrce_pkg::WM_M4: good_len = 8;
				wrce_pkg::WM_M5: good_len = 27;
				default: good_len = $urandom_range(8, 12);
			endcase
			phase_bytes = 0;
			// overlong report that saturates the byte count
			if (p == 2) begin
				send_report(66, -1);
				phase_bytes += 66;
			end
			while (phase_bytes < RANDOM_BYTES / NUM_PHASES) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					n = $urandom_range(1, 15);
					flips = -1;
				end else if (pick < 11) begin
					n = $urandom_range(28, 40);
					flips = -1;
				end else if (pick < 21) begin
					n = good_len;
					flips = 0;
				end else if (pick < 33) begin
					n = good_len;
					flips = -1;
				end else begin
					n = good_len;
					flips = $urandom_range(1, 4);
				end
				send_report(n, flips);
				phase_bytes += n;
			end
		end
		calm = 1'b0;
		drain();

		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
